[hdl/lru_colour_pkg.sv]
// Package for the LRU stream colour assigner.
// Holds widths, constants and the sequencer state type; depends on nothing.
package lru_colour_pkg;

    localparam int ID_W          = 32;
    localparam int STAMP_W       = 32;
    localparam int SLOT_W        = 3;
    localparam int COLOUR_W      = 6;
    localparam int DEF_NUM_SLOTS = 6;
    localparam int MAX_NUM_SLOTS = 8;

    // Colour codes start at this value for slot zero.
    localparam logic [COLOUR_W-1:0] COLOUR_BASE = 6'd31;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_OUT
    } t_state;

endpackage

[hdl/lru_stream_colour_assigner.sv]
// A zero id skips the scan and its word is presented in the cycle after acceptance; a nonzero
// id is scanned over up to NUM_SLOTS slots, then the table is written, then the word is presented.
// No new id is accepted until the receiver has taken the previous word.
// The scan compares one slot per cycle, exiting early on a tag match.
// Reset (synchronous, active low) clears tags, timestamps, the use counter and the sequencer.
// Depends on lru_colour_pkg.
module lru_stream_colour_assigner
    import lru_colour_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [ID_W-1:0]     i_stream_id,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SLOT_W-1:0]   o_slot_index,
    output logic [COLOUR_W-1:0] o_colour_code,
    output logic                o_was_hit
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    t_state r_state;
    t_state n_state;

    // Slot table, small enough to live in flip-flops.
    logic [ID_W-1:0]    r_tags   [NUM_SLOTS];
    logic [STAMP_W-1:0] r_stamps [NUM_SLOTS];
    logic [STAMP_W-1:0] r_count;

    // Working registers of the current word.
    logic [ID_W-1:0]    r_id;
    logic [IDX_W-1:0]   r_idx;
    logic [STAMP_W-1:0] r_best;
    logic [IDX_W-1:0]   r_min;
    logic [IDX_W-1:0]   r_pick;
    logic               r_hit;

    // Result registers.
    logic [SLOT_W-1:0]   r_slot;
    logic [COLOUR_W-1:0] r_colour;
    logic                r_was_hit;

    logic               w_in_accept;
    logic               w_match;
    logic               w_older;
    logic [IDX_W-1:0]   w_sel;
    logic [STAMP_W-1:0] w_count_inc;

    // Shared compare unit, looking at one slot per cycle.
    assign w_match     = (r_tags[r_idx] == r_id);
    assign w_older     = (r_stamps[r_idx] < r_best);
    assign w_sel       = r_hit ? r_pick : r_min;
    assign w_count_inc = r_count + STAMP_W'(1);
    assign w_in_accept = i_valid && o_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = (i_stream_id == '0) ? ST_OUT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_match || (r_idx == LAST_IDX)) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs follow the state.
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_ready = 1'b1;
            ST_OUT:   o_valid = 1'b1;
            default: begin
                o_ready = 1'b0;
                o_valid = 1'b0;
            end
        endcase
    end

    assign o_slot_index  = r_slot;
    assign o_colour_code = r_colour;
    assign o_was_hit     = r_was_hit;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Table and counter: cleared by reset, written once per nonzero word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_tags[k]   <= '0;
                r_stamps[k] <= '0;
            end
            r_count <= '0;
        end else begin
            if (w_in_accept && (i_stream_id != '0)) begin
                r_count <= w_count_inc;
            end
            if (r_state == ST_WRITE) begin
                r_stamps[w_sel] <= r_count;
                if (!r_hit) begin
                    r_tags[w_sel] <= r_id;
                end
            end
        end
    end

    // Scan registers and result word.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_stream_id == '0) begin
                        r_slot    <= '0;
                        r_colour  <= '0;
                        r_was_hit <= 1'b0;
                    end
                    r_id   <= i_stream_id;
                    r_best <= w_count_inc;
                    r_idx  <= '0;
                    r_min  <= '0;
                    r_pick <= '0;
                    r_hit  <= 1'b0;
                end
            end
            ST_SCAN: begin
                if (w_match) begin
                    r_hit  <= 1'b1;
                    r_pick <= r_idx;
                end else begin
                    if (w_older) begin
                        r_best <= r_stamps[r_idx];
                        r_min  <= r_idx;
                    end
                    if (r_idx != LAST_IDX) begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
            end
            ST_WRITE: begin
                r_slot    <= SLOT_W'(w_sel);
                r_colour  <= COLOUR_BASE + COLOUR_W'(w_sel);
                r_was_hit <= r_hit;
            end
            default: begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // A nonzero colour code is always the base plus the slot.
    a_colour_tracks_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_colour_code != '0)) |->
            (o_colour_code == COLOUR_BASE + COLOUR_W'(o_slot_index)))
        else $error("colour code does not match slot index");

    // A hit always reports a real slot with a colour.
    a_hit_has_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_hit) |-> (o_colour_code != '0))
        else $error("hit word carries colour zero");

    // A zero id is answered in the next cycle with the all-zero word.
    a_zero_id_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && (i_stream_id == '0)) |=>
            (o_valid && (o_colour_code == '0) && (o_slot_index == '0) && !o_was_hit))
        else $error("zero id not answered with the zero word");

    // Slot index never leaves the table.
    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_slot_index) < 32'(NUM_SLOTS)))
        else $error("slot index beyond table");

    // The use counter moves only when a nonzero id is accepted.
    a_counter_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_in_accept && (i_stream_id != '0)) |=> $stable(r_count))
        else $error("use counter changed without a nonzero word");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for lru_stream_colour_assigner.
// Predicts slot, colour code and hit flag for each stream id with its own LRU table,
// drives ids through a valid/ready word interface and checks each result; uses lru_colour_pkg.
module testbench;
    import lru_colour_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS   = DEF_NUM_SLOTS;
    localparam int CYCLE_LIMIT = 200_000;

    // One result word: slot, colour code and hit flag.
    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [COLOUR_W-1:0] colour;
        logic                hit;
    } t_colour_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [ID_W-1:0]     i_stream_id;
    logic                o_valid;
    logic                i_ready;
    logic [SLOT_W-1:0]   o_slot_index;
    logic [COLOUR_W-1:0] o_colour_code;
    logic                o_was_hit;

    // Predicted table contents.
    logic [ID_W-1:0]    tag_table   [MAX_NUM_SLOTS];
    logic [STAMP_W-1:0] stamp_table [MAX_NUM_SLOTS];
    logic [STAMP_W-1:0] use_count;

    t_colour_word expected_words[$];
    logic [ID_W-1:0] id_pool[10];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int words_sent     = 0;
    int words_checked  = 0;
    int hit_count      = 0;
    int miss_count     = 0;
    int zero_count     = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    lru_stream_colour_assigner #(
        .NUM_SLOTS(NUM_SLOTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_stream_id  (i_stream_id),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_slot_index (o_slot_index),
        .o_colour_code(o_colour_code),
        .o_was_hit    (o_was_hit)
    );

    always #4 i_clk = ~i_clk;

    // Works out the slot for one id and updates the predicted table.
    function automatic t_colour_word assign_colour(input logic [ID_W-1:0] id);
        t_colour_word       w;
        logic [STAMP_W-1:0] oldest;
        logic               found;
        w = '0;
        if (id == '0) begin
            return w;
        end
        use_count = use_count + 1'b1;
        found = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (!found && tag_table[k] == id) begin
                w.slot = SLOT_W'(k);
                found  = 1'b1;
            end
        end
        // On a miss the strictly oldest stamp below the new count is replaced.
        if (!found) begin
            oldest = use_count;
            w.slot = '0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                if (stamp_table[k] < oldest) begin
                    oldest = stamp_table[k];
                    w.slot = SLOT_W'(k);
                end
            end
            tag_table[w.slot] = id;
        end
        stamp_table[w.slot] = use_count;
        w.colour = COLOUR_BASE + COLOUR_W'(w.slot);
        w.hit    = found;
        return w;
    endfunction

    // Sends one id word; valid stays high between back-to-back words.
    task automatic send_word(input logic [ID_W-1:0] id);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid     <= 1'b1;
        i_stream_id <= id;
        do @(posedge i_clk); while (!o_ready);
        expected_words.push_back(assign_colour(id));
        words_sent++;
    endtask

    // Compares one accepted result word with the oldest prediction.
    task automatic check_word();
        t_colour_word exp_w;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected word slot=%0d colour=%0d hit=%0b",
                     $time, o_slot_index, o_colour_code, o_was_hit);
            error_count++;
            return;
        end
        exp_w = expected_words.pop_front();
        words_checked++;
        if (o_slot_index !== exp_w.slot) begin
            $display("%0t: slot_index expected %0d actual %0d",
                     $time, exp_w.slot, o_slot_index);
            error_count++;
        end
        if (o_colour_code !== exp_w.colour) begin
            $display("%0t: colour_code expected %0d actual %0d",
                     $time, exp_w.colour, o_colour_code);
            error_count++;
        end
        if (o_was_hit !== exp_w.hit) begin
            $display("%0t: was_hit expected %0b actual %0b",
                     $time, exp_w.hit, o_was_hit);
            error_count++;
        end
        if (exp_w.colour == '0) begin
            zero_count++;
        end else if (exp_w.hit) begin
            hit_count++;
        end else begin
            miss_count++;
        end
    endtask

    // Receiver: random stalls on ready, check on every accepted word.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_valid && i_ready) begin
            check_word();
        end
    end

    // Zero stream gives the blank colour and leaves the table alone.
    task automatic test_zero_stream();
        send_word('0);
    endtask

    // A fresh table fills slot by slot, lowest index first.
    task automatic test_fresh_fill();
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0001);
        send_word('0);
        send_word(32'h8000_0000);
        send_word(32'hAAAA_AAAA);
        send_word(32'h5555_5555);
        send_word(32'h1234_5678);
    endtask

    // Known ids hit their own slots and refresh their stamps.
    task automatic test_hits();
        send_word(32'h0000_0001);
        send_word(32'hFFFF_FFFF);
        send_word(32'h5555_5555);
        send_word(32'h5555_5555);
        send_word('0);
    endtask

    // New ids evict the least recently used entries; an evicted id misses again.
    task automatic test_lru_eviction();
        send_word(32'h0000_0007);
        send_word(32'h0000_0009);
        send_word(32'h0000_000B);
        send_word(32'h8000_0000);
        send_word(32'h0000_0007);
    endtask

    // Random ids, mostly from a small pool so hits and evictions mix.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        int               pool_size;
        int               pick;
        logic [ID_W-1:0]  id;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        pool_size = $urandom_range(7, 10);
        for (int k = 0; k < pool_size; k++) begin
            id_pool[k] = $urandom_range(32'hFFFF_FFFF, 1);
        end
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                id = '0;
            end else if (pick < 25) begin
                id = $urandom;
            end else begin
                id = id_pool[$urandom_range(pool_size - 1)];
            end
            send_word(id);
        end
    endtask

    // Cycle limit guards against a hung handshake.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d words outstanding", $time, expected_words.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main sequence.
    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_ready     <= 1'b0;
        i_stream_id <= '0;
        for (int k = 0; k < MAX_NUM_SLOTS; k++) begin
            tag_table[k]   = '0;
            stamp_table[k] = '0;
        end
        use_count = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_stream();
        test_fresh_fill();
        test_hits();
        test_lru_eviction();

        test_random_traffic(0, 0, 125);
        test_random_traffic(55, 0, 125);
        test_random_traffic(0, 55, 125);
        test_random_traffic(22, 22, 125);

        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (NUM_SLOTS + 4) @(posedge i_clk);

        $display("Sent %0d ids, checked %0d words: %0d hits, %0d replacements, %0d zero ids.",
                 words_sent, words_checked, hit_count, miss_count, zero_count);
        $display("Idling phases: none, sender gaps, receiver stalls, both.");
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
